/* sv/bfm_pkg.sv */
// Shared types, sizes and codes of the brainfuck machine core.
// Used by the top level; has no dependencies of its own.
`default_nettype none

package bfm_pkg;

  localparam int unsigned ProgDepth = 4096;
  localparam int unsigned NestDepth = 512;
  localparam int unsigned TapeCells = 65536;

  localparam int unsigned ProgAw  = $clog2(ProgDepth);
  localparam int unsigned LposW   = ProgAw + 1;
  localparam int unsigned NestAw  = $clog2(NestDepth);
  localparam int unsigned DepthW  = $clog2(NestDepth + 1);
  localparam int unsigned TapeAw  = $clog2(TapeCells);
  localparam int unsigned OpW     = 4;
  localparam int unsigned EntryW  = OpW + ProgAw;
  localparam int unsigned CellW   = 16;

  localparam logic [7:0] CharRight = 8'h3E;
  localparam logic [7:0] CharLeft  = 8'h3C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPut   = 8'h2E;
  localparam logic [7:0] CharGet   = 8'h2C;
  localparam logic [7:0] CharOpen  = 8'h5B;
  localparam logic [7:0] CharClose = 8'h5D;

  typedef enum logic [OpW-1:0] {
    OpEnd   = 4'd0,
    OpRight = 4'd1,
    OpLeft  = 4'd2,
    OpPlus  = 4'd3,
    OpMinus = 4'd4,
    OpPut   = 4'd5,
    OpGet   = 4'd6,
    OpOpen  = 4'd7,
    OpClose = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    ModeLoading  = 3'd0,
    ModeLoadFail = 3'd1,
    ModeRunning  = 3'd2,
    ModeHalted   = 3'd3,
    ModeRunFail  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    FuncLoad = 2'd0,
    FuncEnd  = 2'd1,
    FuncExec = 2'd2,
    FuncNone = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StWork  = 4'b0100,
    StClose = 4'b1000
  } state_e;

  typedef struct packed {
    mode_e      status;
    logic       input_taken;
    logic [7:0] out_byte;
    logic       out_valid;
  } result_t;

endpackage

`default_nettype wire

/* sv/bfm_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
// No dependencies; used for the program store, the bracket stack and the tape.
`default_nettype none

module bfm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/brainfuck_machine_core.sv */
// Top level of the brainfuck machine: loader, executor and result register.
// Depends on bfm_pkg and bfm_ram.
//
//   Channel  Signals                      Payload
//   s_axis   tvalid tready tdata tuser    tuser: func; tdata: byte_in, input_ended
//   m_axis   tvalid tready tdata          tdata: out_valid, out_byte, input_taken, status
//
// For every item the memories are read in the cycle of the transfer, and the work is done
// and written back in the work state. A matched closing bracket while loading also passes
// the close state, as both of its program entries are written through the one write port.
// After reset the tape is cleared one cell per cycle with s_axis_tready low.
// A result waits in the output register; the next item stalls only in its final state.
`default_nettype none

module brainfuck_machine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // byte_in[7:0], input_ended[8], zeros
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata   // out_valid[0], out_byte[8:1], input_taken[9],
                                          // status[12:10], zeros
);

  import bfm_pkg::*;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [TapeAw-1:0] clr_q, clr_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [LposW-1:0]  lpos_q, lpos_d;
  logic [ProgAw-1:0] pc_q, pc_d;
  logic [TapeAw-1:0] ptr_q, ptr_d;
  logic              m_valid_q;
  result_t           res_q, res_d;
  func_e             func_q;
  logic [7:0]        byte_q;
  logic              ended_q;

  logic              accept, out_free, fin;
  logic              prog_we, stack_we, tape_we;
  logic [ProgAw-1:0] prog_waddr;
  logic [EntryW-1:0] prog_wdata, prog_rdata;
  logic [ProgAw-1:0] stack_rdata;
  logic [TapeAw-1:0] tape_waddr;
  logic [CellW-1:0]  tape_wdata, tape_rdata;
  logic [NestAw-1:0] stack_raddr;

  logic              is_cmd;
  opcode_e           ch_op, ex_op;
  logic [ProgAw-1:0] ex_tgt, npc;
  logic [ProgAw-1:0] lpos_lo;
  logic              pos_full, pos_last;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign stack_raddr = NestAw'(depth_q - DepthW'(1));
  assign ex_op       = opcode_e'(prog_rdata[EntryW-1 -: OpW]);
  assign ex_tgt      = prog_rdata[ProgAw-1:0];
  assign lpos_lo     = lpos_q[ProgAw-1:0];
  assign pos_full    = lpos_q >= LposW'(ProgDepth);
  assign pos_last    = lpos_q == LposW'(ProgDepth - 1);

  always_comb begin
    is_cmd = 1'b1;
    ch_op  = OpEnd;
    case (byte_q)
      CharRight: ch_op = OpRight;
      CharLeft:  ch_op = OpLeft;
      CharPlus:  ch_op = OpPlus;
      CharMinus: ch_op = OpMinus;
      CharPut:   ch_op = OpPut;
      CharGet:   ch_op = OpGet;
      CharOpen:  ch_op = OpOpen;
      CharClose: ch_op = OpClose;
      default:   is_cmd = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    clr_d      = clr_q;
    depth_d    = depth_q;
    lpos_d     = lpos_q;
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    fin        = 1'b0;
    prog_we    = 1'b0;
    prog_waddr = lpos_lo;
    prog_wdata = '0;
    stack_we   = 1'b0;
    tape_we    = 1'b0;
    tape_waddr = ptr_q;
    tape_wdata = '0;
    npc        = pc_q;
    res_d      = '{status: ModeLoading, input_taken: 1'b0, out_byte: 8'h00, out_valid: 1'b0};

    case (state_q)
      StClear: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        clr_d      = clr_q + TapeAw'(1);
        if (clr_q == TapeAw'(TapeCells - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StWork;
        end
      end
      StWork: begin
        if (mode_q == ModeLoading && func_q == FuncLoad && is_cmd && !pos_full &&
            ch_op == OpClose && depth_q != '0) begin
          prog_we    = 1'b1;
          prog_wdata = {OpClose, stack_rdata};
          state_d    = StClose;
        end else if (out_free) begin
          fin     = 1'b1;
          state_d = StIdle;
          if (mode_q == ModeLoading && func_q == FuncLoad) begin
            if (is_cmd) begin
              if (pos_full) begin
                mode_d = ModeLoadFail;
              end else if (ch_op == OpOpen && depth_q == DepthW'(NestDepth)) begin
                mode_d = ModeLoadFail;
              end else if (ch_op == OpClose) begin
                mode_d = ModeLoadFail;
              end else begin
                prog_we    = 1'b1;
                prog_wdata = {ch_op, {ProgAw{1'b0}}};
                if (ch_op == OpOpen) begin
                  stack_we = 1'b1;
                  depth_d  = depth_q + DepthW'(1);
                end
                lpos_d = lpos_q + LposW'(1);
                if (pos_last) begin
                  mode_d = ModeLoadFail;
                end
              end
            end
          end else if (mode_q == ModeLoading && func_q == FuncEnd) begin
            if (depth_q != '0 || pos_full) begin
              mode_d = ModeLoadFail;
            end else begin
              prog_we    = 1'b1;
              prog_wdata = {OpEnd, {ProgAw{1'b0}}};
              mode_d     = ModeRunning;
              ptr_d      = '0;
              pc_d       = '0;
            end
          end else if (mode_q == ModeRunning && func_q == FuncExec) begin
            case (ex_op)
              OpEnd: mode_d = ModeHalted;
              OpRight: begin
                if (ptr_q == TapeAw'(TapeCells - 1)) begin
                  mode_d = ModeRunFail;
                end else begin
                  ptr_d = ptr_q + TapeAw'(1);
                end
              end
              OpLeft: begin
                if (ptr_q == '0) begin
                  mode_d = ModeRunFail;
                end else begin
                  ptr_d = ptr_q - TapeAw'(1);
                end
              end
              OpPlus: begin
                tape_we    = 1'b1;
                tape_wdata = tape_rdata + CellW'(1);
              end
              OpMinus: begin
                tape_we    = 1'b1;
                tape_wdata = tape_rdata - CellW'(1);
              end
              OpPut: begin
                res_d.out_valid = 1'b1;
                res_d.out_byte  = tape_rdata[7:0];
              end
              OpGet: begin
                tape_we = 1'b1;
                if (ended_q) begin
                  tape_wdata = {CellW{1'b1}};
                end else begin
                  tape_wdata        = CellW'(byte_q);
                  res_d.input_taken = 1'b1;
                end
              end
              OpOpen: begin
                if (tape_rdata == '0) begin
                  npc = ex_tgt;
                end
              end
              OpClose: begin
                if (tape_rdata != '0) begin
                  npc = ex_tgt;
                end
              end
              default: mode_d = ModeRunFail;
            endcase
            if (mode_d == ModeRunning) begin
              if (npc == ProgAw'(ProgDepth - 1)) begin
                pc_d = '0;
              end else begin
                pc_d = npc + ProgAw'(1);
              end
            end
          end
        end
      end
      StClose: begin
        if (out_free) begin
          fin        = 1'b1;
          state_d    = StIdle;
          prog_we    = 1'b1;
          prog_waddr = stack_rdata;
          prog_wdata = {OpOpen, lpos_lo};
          depth_d    = depth_q - DepthW'(1);
          lpos_d     = lpos_q + LposW'(1);
          if (pos_last) begin
            mode_d = ModeLoadFail;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    res_d.status = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      mode_q    <= ModeLoading;
      clr_q     <= '0;
      depth_q   <= '0;
      lpos_q    <= '0;
      pc_q      <= '0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      clr_q   <= clr_d;
      depth_q <= depth_d;
      lpos_q  <= lpos_d;
      pc_q    <= pc_d;
      ptr_q   <= ptr_d;
      if (fin) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_e'(s_axis_tuser);
      byte_q  <= s_axis_tdata[7:0];
      ended_q <= s_axis_tdata[8];
    end
    if (fin) begin
      res_q <= res_d;
    end
  end

  bfm_ram #(.Width(EntryW), .Depth(ProgDepth)) u_prog (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .re_i    (accept),
    .raddr_i (pc_q),
    .rdata_o (prog_rdata)
  );

  bfm_ram #(.Width(ProgAw), .Depth(NestDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (depth_q[NestAw-1:0]),
    .wdata_i (lpos_lo),
    .re_i    (accept),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  bfm_ram #(.Width(CellW), .Depth(TapeCells)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (tape_rdata)
  );

  assign s_axis_tready = state_q == StIdle;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.status, res_q.input_taken, res_q.out_byte,
                          res_q.out_valid};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("item accepted while another is still in progress");

  a_terminal_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeLoadFail || mode_q == ModeHalted || mode_q == ModeRunFail)
    |=> $stable(mode_q))
    else $error("terminal mode was left without reset");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten before its transfer");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !(prog_we || stack_we || tape_we))
    else $error("memory written while no item is in progress");

endmodule

`default_nettype wire

/* bench/bfm_run_checker.sv */
`timescale 1ns / 100ps
// Checker for the brainfuck machine core: it watches both stream channels, keeps its own
// copy of the loader and executor state, and compares every result transfer against it.
// Depends on bfm_pkg.

module bfm_run_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_in[7:0], input_ended[8], zeros
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // out_valid[0], out_byte[8:1], input_taken[9],
                                      // status[12:10], zeros
  output int          errors_o,
  output int          pending_o
);
  import bfm_pkg::*;

  opcode_e           code_op   [ProgDepth];
  logic [ProgAw-1:0] code_link [ProgDepth];
  logic [ProgAw-1:0] nest_stack [NestDepth];
  logic [CellW-1:0]  tape [TapeCells];
  logic [DepthW-1:0] nest_count;
  logic [LposW-1:0]  text_len;
  logic [ProgAw-1:0] pc;
  logic [TapeAw:0]   head;
  mode_e             machine_mode;

  result_t due_results [$];
  result_t got_res;
  result_t want_res;
  result_t next_res;
  int      result_idx;

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    result_idx = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors_o++;
    $display("%0t: result %0d: %s is %0h, expected %0h", $time, result_idx, what, got, want);
  endtask

  task automatic load_char(input logic [7:0] ch);
    opcode_e           op;
    logic [ProgAw-1:0] pos;
    logic [ProgAw-1:0] open_pos;
    logic              known;
    known = 1'b1;
    op    = OpEnd;
    pos   = text_len[ProgAw-1:0];
    case (ch)
      CharRight: op = OpRight;
      CharLeft:  op = OpLeft;
      CharPlus:  op = OpPlus;
      CharMinus: op = OpMinus;
      CharPut:   op = OpPut;
      CharGet:   op = OpGet;
      CharOpen:  op = OpOpen;
      CharClose: op = OpClose;
      default:   known = 1'b0;
    endcase
    if (!known) return;
    if (text_len >= ProgDepth) begin
      machine_mode = ModeLoadFail;
      return;
    end
    if (op == OpOpen) begin
      if (nest_count >= NestDepth) begin
        machine_mode = ModeLoadFail;
        return;
      end
      nest_stack[nest_count[NestAw-1:0]] = pos;
      nest_count = nest_count + 1'b1;
      code_link[pos] = '0;
    end else if (op == OpClose) begin
      if (nest_count == 0) begin
        machine_mode = ModeLoadFail;
        return;
      end
      nest_count = nest_count - 1'b1;
      open_pos = nest_stack[nest_count[NestAw-1:0]];
      code_link[pos] = open_pos;
      code_link[open_pos] = pos;
    end else begin
      code_link[pos] = '0;
    end
    code_op[pos] = op;
    text_len = text_len + 1'b1;
    if (text_len >= ProgDepth) machine_mode = ModeLoadFail;
  endtask

  task automatic finish_text();
    if (nest_count != 0 || text_len >= ProgDepth) begin
      machine_mode = ModeLoadFail;
      return;
    end
    code_op[text_len[ProgAw-1:0]]   = OpEnd;
    code_link[text_len[ProgAw-1:0]] = '0;
    for (int i = 0; i < TapeCells; i++) tape[i] = '0;
    head = '0;
    pc = '0;
    machine_mode = ModeRunning;
  endtask

  task automatic exec_one(input logic [7:0] ch, input logic ended, inout result_t res);
    opcode_e           op;
    logic [CellW-1:0]  cur_val;
    logic [TapeAw-1:0] slot;
    logic              advance;
    op      = code_op[pc];
    slot    = head[TapeAw-1:0];
    cur_val = tape[slot];
    advance = 1'b1;
    case (op)
      OpEnd: begin
        machine_mode = ModeHalted;
        advance = 1'b0;
      end
      OpRight: begin
        if (head + 1 >= TapeCells) begin
          machine_mode = ModeRunFail;
          advance = 1'b0;
        end else begin
          head = head + 1'b1;
        end
      end
      OpLeft: begin
        if (head == 0) begin
          machine_mode = ModeRunFail;
          advance = 1'b0;
        end else begin
          head = head - 1'b1;
        end
      end
      OpPlus:  tape[slot] = cur_val + 1'b1;
      OpMinus: tape[slot] = cur_val - 1'b1;
      OpPut: begin
        res.out_valid = 1'b1;
        res.out_byte  = cur_val[7:0];
      end
      OpGet: begin
        if (ended) begin
          tape[slot] = 16'hFFFF;
        end else begin
          tape[slot] = {8'h00, ch};
          res.input_taken = 1'b1;
        end
      end
      OpOpen: begin
        if (cur_val == 0) pc = code_link[pc];
      end
      OpClose: begin
        if (cur_val != 0) pc = code_link[pc];
      end
      default: begin
        machine_mode = ModeRunFail;
        advance = 1'b0;
      end
    endcase
    if (advance) pc = pc + 1'b1;
  endtask

  task automatic step_machine(input func_e fn, input logic [7:0] ch, input logic ended,
                              output result_t res);
    res = '0;
    if (machine_mode == ModeLoading && fn == FuncLoad) load_char(ch);
    else if (machine_mode == ModeLoading && fn == FuncEnd) finish_text();
    else if (machine_mode == ModeRunning && fn == FuncExec) exec_one(ch, ended, res);
    res.status = machine_mode;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      nest_count   = '0;
      text_len     = '0;
      pc           = '0;
      head         = '0;
      machine_mode = ModeLoading;
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", int'(m_axis_tdata), 0);
        end else begin
          want_res = due_results.pop_front();
          if (got_res.out_valid !== want_res.out_valid)
            report_mismatch("out_valid", int'(got_res.out_valid), int'(want_res.out_valid));
          if (got_res.out_byte !== want_res.out_byte)
            report_mismatch("out_byte", int'(got_res.out_byte), int'(want_res.out_byte));
          if (got_res.input_taken !== want_res.input_taken)
            report_mismatch("input_taken", int'(got_res.input_taken),
                            int'(want_res.input_taken));
          if (got_res.status !== want_res.status)
            report_mismatch("status", int'(got_res.status), int'(want_res.status));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_machine(func_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8], next_res);
        due_results.push_back(next_res);
      end
    end
    pending_o = due_results.size();
  end

endmodule

/* bench/brainfuck_machine_core_test.sv */
`timescale 1ns / 100ps
// Top of the brainfuck machine core bench: clock, reset, program and step stimulus with
// random gaps and stalls on both channels, and the verdict.
// Depends on bfm_pkg, brainfuck_machine_core and bfm_run_checker.

module brainfuck_machine_core_test;
  import bfm_pkg::*;

  localparam int StallLimit = 300000;
  localparam int ExecItems  = 300;
  localparam int CalmItems  = 50;
  localparam int HoldAfter  = 100;
  localparam int HoldCycles = 400;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;

  int  errors;
  int  pending;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  logic calm = 1'b0;

  byte unsigned prog_text [$];
  int  ptr_at;
  int  ptr_top;

  always #5 clk_i = ~clk_i;

  brainfuck_machine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bfm_run_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("brainfuck_machine_core_test: FAIL");
      $finish;
    end
  end

  task automatic send_item(input func_e fn, input logic [7:0] val, input logic ended);
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {7'd0, ended, val};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {CharRight, CharLeft, CharPlus, CharMinus,
                     CharPut, CharGet, CharOpen, CharClose});
    return c;
  endfunction

  task automatic append(input string s);
    for (int i = 0; i < s.len(); i++) prog_text.push_back(s[i]);
  endtask

  task automatic to_fresh();
    while (ptr_at <= ptr_top) begin
      append(">");
      ptr_at++;
    end
    ptr_top = ptr_at;
  endtask

  // Loops only ever run on cells that are still zero on entry or are set by a small
  // count of increments, so every loop ends after a few passes.
  task automatic build_program();
    append(">>,.+-.<>>[]+[-.]>-.+");
    ptr_at  = 4;
    ptr_top = 4;
    repeat ($urandom_range(16, 22)) begin
      case ($urandom_range(0, 2))
        0: begin
          to_fresh();
          repeat ($urandom_range(1, 4)) append("+");
          append("[");
          repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 3))
              0: append(".");
              1: append(">++<");
              2: append(">[-]<");
              default: append(">.<");
            endcase
          end
          append("-]");
          ptr_top = ptr_at + 1;
        end
        1: begin
          repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 5))
              0: append("+");
              1: append("-");
              2: append(".");
              3: append(",");
              4: begin
                append(">");
                ptr_at++;
                if (ptr_at > ptr_top) ptr_top = ptr_at;
              end
              default: begin
                if (ptr_at > 1) begin
                  append("<");
                  ptr_at--;
                end else begin
                  append(".");
                end
              end
            endcase
          end
        end
        default: begin
          to_fresh();
          append("[");
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0: append("+<");
              1: append(",.");
              2: append("[>]");
              default: append("-");
            endcase
          end
          append("]");
        end
      endcase
    end
    // Half of the runs walk off the low end of the tape instead of halting.
    if ($urandom_range(0, 1) == 1) repeat (ptr_at + 1) append("<");
  endtask

  initial begin : receiver
    logic held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int n;
    build_program();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(FuncNone, 8'hFF, 1'b1);
    send_item(FuncExec, 8'h00, 1'b0);
    send_item(FuncLoad, 8'h00, 1'b1);
    send_item(FuncLoad, 8'hFF, 1'b0);

    foreach (prog_text[i]) begin
      send_item(FuncLoad, prog_text[i], 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 19))
        0, 1, 2: send_item(FuncLoad, noise_char(), 1'($urandom_range(0, 1)));
        3:       send_item(FuncExec, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        4:       send_item(FuncNone, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: ;
      endcase
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    send_item(FuncEnd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    for (n = 0; n < ExecItems; n++) begin
      calm = (ExecItems - n <= CalmItems);
      if (n < 4) begin
        send_item(FuncExec, 8'hFF, 1'b0);
      end else if ($urandom_range(0, 19) == 0) begin
        send_item(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(FuncExec, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("brainfuck_machine_core_test: PASS");
    end else begin
      $display("brainfuck_machine_core_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bfm_pkg.sv
sv/bfm_ram.sv
sv/brainfuck_machine_core.sv
bench/bfm_run_checker.sv
bench/brainfuck_machine_core_test.sv
